// ----- rtl/alif_pkg.sv -----
`timescale 1ns / 1ps

package alif_pkg;

   localparam int DATA_WIDTH          = 32;
   localparam int FRAC_BITS           = 16;
   localparam int RATIO_WIDTH         = 16;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [DATA_WIDTH-1:0]      word_type;
   typedef logic [RATIO_WIDTH-1:0]     ratio_type;

   localparam csr_index_type REG_DECAY_FACTOR    = 3'd0;
   localparam csr_index_type REG_STEP_RATIO      = 3'd1;
   localparam csr_index_type REG_REST_POTENTIAL  = 3'd2;
   localparam csr_index_type REG_EXTERNAL_DRIVE  = 3'd3;
   localparam csr_index_type REG_SYNAPTIC_GAIN   = 3'd4;
   localparam csr_index_type REG_ADAPTATION_GAIN = 3'd5;
   localparam csr_index_type REG_SPIKE_THRESHOLD = 3'd6;

   localparam ratio_type DECAY_FACTOR_RESET    = 16'd65535;
   localparam ratio_type STEP_RATIO_RESET      = 16'd655;
   localparam word_type  REST_POTENTIAL_RESET  = 32'd0;
   localparam word_type  EXTERNAL_DRIVE_RESET  = 32'd0;
   localparam word_type  SYNAPTIC_GAIN_RESET   = 32'd65536;
   localparam word_type  ADAPTATION_GAIN_RESET = 32'd0;
   localparam word_type  SPIKE_THRESHOLD_RESET = 32'd65536;

endpackage

// ----- rtl/alif_if.sv -----
`timescale 1ns / 1ps

interface alif_req_if;
   logic                            valid;
   logic                            ready;
   logic [alif_pkg::DATA_WIDTH-1:0] syn_input;

   modport source (output valid, output syn_input, input ready);
   modport sink   (input valid, input syn_input, output ready);
endinterface

interface alif_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [alif_pkg::DATA_WIDTH-1:0] membrane_potential;
   logic                            spike;

   modport source (output valid, output membrane_potential, output spike, input ready);
   modport sink   (input valid, input membrane_potential, input spike, output ready);
endinterface

// ----- rtl/adaptive_lif_neuron_rk4_unit.sv -----
`timescale 1ns / 1ps

// Adaptive leaky integrate-and-fire neuron, one time step per request beat. Each step
// decays the synaptic and adaptation currents, forms the drive, takes one fourth-order
// Runge-Kutta step of the membrane potential and fires when the potential rises strictly
// above the threshold, which resets it to the rest potential. All arithmetic runs through
// one shared signed VALUE_WIDTH x 17 multiplier under a sequencer: ten multiplier passes,
// the adds between them, and a final divide by six done eight bits a cycle. The request side
// is ready only while the sequencer is idle. A finished response waits in an output register,
// so the next beat can be taken before the previous response is consumed. Configuration
// registers are written through the csr port and should only be changed while no step is in
// flight.
module adaptive_lif_neuron_rk4_unit #(
   parameter int VALUE_WIDTH = alif_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   alif_req_if.sink                 req_bus,
   alif_rsp_if.source               rsp_bus,
   input  logic                     csr_write_en,
   input  alif_pkg::csr_index_type  csr_index,
   input  alif_pkg::word_type       csr_wdata
);

   import alif_pkg::*;

   localparam int WIDE    = VALUE_WIDTH + 18;
   localparam int PW      = VALUE_WIDTH + RATIO_WIDTH + 1;
   localparam int SW      = VALUE_WIDTH + 3;
   localparam int NPAIR   = (SW + 1) / 2;
   localparam int DIV_CYC = (NPAIR + 3) / 4;
   localparam int DB      = 8 * DIV_CYC;
   localparam int CW      = $clog2(DIV_CYC + 1);

   localparam logic signed [WIDE-1:0] MAX_W =
      {{(WIDE-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE-1:0] MIN_W =
      {{(WIDE-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [WIDE-1:0] ONE_Q  = WIDE'(1) << FRAC_BITS;
   localparam logic signed [WIDE-1:0] ONE_VW = WIDE'(1) << VALUE_WIDTH;
   localparam logic signed [WIDE-1:0] SIX_VW = WIDE'(6) << VALUE_WIDTH;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_SYN_M     = 5'd1;
   localparam logic [4:0] S_SYN_A     = 5'd2;
   localparam logic [4:0] S_ADP_M     = 5'd3;
   localparam logic [4:0] S_ADP_A     = 5'd4;
   localparam logic [4:0] S_SG_LO_M   = 5'd5;
   localparam logic [4:0] S_SG_LO_A   = 5'd6;
   localparam logic [4:0] S_SG_HI_M   = 5'd7;
   localparam logic [4:0] S_SG_HI_A   = 5'd8;
   localparam logic [4:0] S_DRV_EXT   = 5'd9;
   localparam logic [4:0] S_AG_LO_M   = 5'd10;
   localparam logic [4:0] S_AG_LO_A   = 5'd11;
   localparam logic [4:0] S_AG_HI_M   = 5'd12;
   localparam logic [4:0] S_AG_HI_A   = 5'd13;
   localparam logic [4:0] S_DRV_ADP   = 5'd14;
   localparam logic [4:0] S_K_F       = 5'd15;
   localparam logic [4:0] S_K_M       = 5'd16;
   localparam logic [4:0] S_K_A       = 5'd17;
   localparam logic [4:0] S_DIV_LOAD  = 5'd18;
   localparam logic [4:0] S_DIV       = 5'd19;
   localparam logic [4:0] S_SUM       = 5'd20;
   localparam logic [4:0] S_FIRE      = 5'd21;

   localparam logic [1:0] K_FIRST = 2'd0;
   localparam logic [1:0] K_THIRD = 2'd2;
   localparam logic [1:0] K_LAST  = 2'd3;

   function automatic logic signed [VALUE_WIDTH-1:0] sat_v(input logic signed [WIDE-1:0] x);
      logic signed [VALUE_WIDTH-1:0] r;
      if (x > MAX_W) begin
         r = MAX_W[VALUE_WIDTH-1:0];
      end else if (x < MIN_W) begin
         r = MIN_W[VALUE_WIDTH-1:0];
      end else begin
         r = x[VALUE_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE-1:0] ext_v(input logic signed [VALUE_WIDTH-1:0] v);
      return {{(WIDE-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
   endfunction

   function automatic logic signed [WIDE-1:0] ext_32(input word_type w);
      return {{(WIDE-DATA_WIDTH){w[DATA_WIDTH-1]}}, w};
   endfunction

   // Four radix-4 long-division steps by three; returns four quotient digits and the remainder.
   function automatic logic [9:0] div3_byte(input logic [1:0] rem, input logic [7:0] bits8);
      logic [1:0] r;
      logic [3:0] v;
      logic [7:0] q;
      r = rem;
      q = '0;
      for (int i = 3; i >= 0; i--) begin
         v = {r, bits8[2*i+1 -: 2]};
         if (v >= 4'd9) begin
            q[2*i+1 -: 2] = 2'd3;
            r = 2'(v - 4'd9);
         end else if (v >= 4'd6) begin
            q[2*i+1 -: 2] = 2'd2;
            r = 2'(v - 4'd6);
         end else if (v >= 4'd3) begin
            q[2*i+1 -: 2] = 2'd1;
            r = 2'(v - 4'd3);
         end else begin
            q[2*i+1 -: 2] = 2'd0;
            r = v[1:0];
         end
      end
      return {q, r};
   endfunction

   // Configuration registers.
   ratio_type decay_ff, step_ff;
   word_type  rest_ff, ext_ff, sgain_ff, again_ff, thr_ff;

   // Sequencer and datapath registers.
   logic [4:0]                    state_ff, state_in;
   word_type                      in_ff, in_in;
   logic signed [VALUE_WIDTH-1:0] syn_ff, syn_in;
   logic signed [VALUE_WIDTH-1:0] adapt_ff, adapt_in;
   logic signed [VALUE_WIDTH-1:0] pot_ff, pot_in;
   logic                          fired_ff, fired_in;
   logic signed [VALUE_WIDTH-1:0] drive_ff, drive_in;
   logic signed [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic signed [VALUE_WIDTH-1:0] x_ff, x_in;
   logic signed [SW-1:0]          sum_ff, sum_in;
   logic [1:0]                    kidx_ff, kidx_in;
   logic [DB-1:0]                 div_ff, div_in;
   logic [DB-1:0]                 quot_ff, quot_in;
   logic [1:0]                    rem_ff, rem_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   word_type                      rsp_pot_ff, rsp_pot_in;
   logic                          rsp_spike_ff, rsp_spike_in;

   // Combinational helpers.
   logic signed [VALUE_WIDTH-1:0] mul_a;
   logic signed [RATIO_WIDTH:0]   mul_b;
   logic signed [WIDE-1:0]        prod_w, prod_sh;
   logic signed [VALUE_WIDTH-1:0] k_v;
   logic signed [SW-1:0]          k_s;
   logic signed [WIDE-1:0]        rest_w, u_w, q6_w;
   logic signed [VALUE_WIDTH-1:0] rest_v;
   logic [9:0]                    div_step;
   logic                          fire;
   logic signed [WIDE-1:0]        pot_next_w;

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.membrane_potential = rsp_pot_ff;
   assign rsp_bus.spike           = rsp_spike_ff;

   always_comb begin
      case (state_ff)
         S_SYN_M: begin
            mul_a = syn_ff;
            mul_b = {1'b0, decay_ff};
         end
         S_ADP_M: begin
            mul_a = adapt_ff;
            mul_b = {1'b0, decay_ff};
         end
         S_SG_LO_M: begin
            mul_a = syn_ff;
            mul_b = {1'b0, sgain_ff[RATIO_WIDTH-1:0]};
         end
         S_SG_HI_M: begin
            mul_a = syn_ff;
            mul_b = {sgain_ff[DATA_WIDTH-1], sgain_ff[DATA_WIDTH-1:RATIO_WIDTH]};
         end
         S_AG_LO_M: begin
            mul_a = adapt_ff;
            mul_b = {1'b0, again_ff[RATIO_WIDTH-1:0]};
         end
         S_AG_HI_M: begin
            mul_a = adapt_ff;
            mul_b = {again_ff[DATA_WIDTH-1], again_ff[DATA_WIDTH-1:RATIO_WIDTH]};
         end
         default: begin
            mul_a = acc_ff;
            mul_b = {1'b0, step_ff};
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_w   = {{(WIDE-PW){prod_ff[PW-1]}}, prod_ff};
   assign prod_sh  = prod_w >>> FRAC_BITS;
   assign k_v      = sat_v(prod_sh);
   assign k_s      = {{(SW-VALUE_WIDTH){k_v[VALUE_WIDTH-1]}}, k_v};
   assign rest_w   = ext_32(rest_ff);
   assign rest_v   = sat_v(rest_w);
   // Bias the weighted sum positive so floor division reduces to unsigned division.
   assign u_w      = {{(WIDE-SW){sum_ff[SW-1]}}, sum_ff} + SIX_VW;
   assign q6_w     = $signed({{(WIDE-SW){1'b0}}, quot_ff[SW-1:0]}) - ONE_VW;
   assign div_step = div3_byte(rem_ff, div_ff[DB-1 -: 8]);
   assign fire     = ext_v(x_ff) > ext_32(thr_ff);
   assign pot_next_w = ext_v(fire ? rest_v : x_ff);

   always_comb begin
      state_in     = state_ff;
      in_in        = in_ff;
      syn_in       = syn_ff;
      adapt_in     = adapt_ff;
      pot_in       = pot_ff;
      fired_in     = fired_ff;
      drive_in     = drive_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      sum_in       = sum_ff;
      kidx_in      = kidx_ff;
      div_in       = div_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pot_in   = rsp_pot_ff;
      rsp_spike_in = rsp_spike_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               in_in    = req_bus.syn_input;
               state_in = S_SYN_M;
            end
         end
         S_SYN_M: state_in = S_SYN_A;
         S_SYN_A: begin
            syn_in   = sat_v(ext_v(k_v) + ext_v(sat_v(ext_32(in_ff))));
            state_in = S_ADP_M;
         end
         S_ADP_M: state_in = S_ADP_A;
         S_ADP_A: begin
            adapt_in = sat_v(ext_v(k_v) + (fired_ff ? ONE_Q : '0));
            state_in = S_SG_LO_M;
         end
         S_SG_LO_M: state_in = S_SG_LO_A;
         S_SG_LO_A: begin
            acc_in   = prod_sh[VALUE_WIDTH-1:0];
            state_in = S_SG_HI_M;
         end
         S_SG_HI_M: state_in = S_SG_HI_A;
         S_SG_HI_A: begin
            acc_in   = sat_v(prod_w + ext_v(acc_ff));
            state_in = S_DRV_EXT;
         end
         S_DRV_EXT: begin
            drive_in = sat_v(ext_v(sat_v(ext_32(ext_ff))) + ext_v(acc_ff));
            state_in = S_AG_LO_M;
         end
         S_AG_LO_M: state_in = S_AG_LO_A;
         S_AG_LO_A: begin
            acc_in   = prod_sh[VALUE_WIDTH-1:0];
            state_in = S_AG_HI_M;
         end
         S_AG_HI_M: state_in = S_AG_HI_A;
         S_AG_HI_A: begin
            acc_in   = sat_v(prod_w + ext_v(acc_ff));
            state_in = S_DRV_ADP;
         end
         S_DRV_ADP: begin
            drive_in = sat_v(ext_v(drive_ff) - ext_v(acc_ff));
            x_in     = pot_ff;
            sum_in   = '0;
            kidx_in  = K_FIRST;
            state_in = S_K_F;
         end
         S_K_F: begin
            acc_in   = sat_v(ext_v(rest_v) - ext_v(x_ff) + ext_v(drive_ff));
            state_in = S_K_M;
         end
         S_K_M: state_in = S_K_A;
         S_K_A: begin
            // The middle two slopes count twice; the third one feeds a full step.
            if (kidx_ff == K_FIRST || kidx_ff == K_LAST) begin
               sum_in = sum_ff + k_s;
            end else begin
               sum_in = sum_ff + (k_s <<< 1);
            end
            if (kidx_ff == K_THIRD) begin
               x_in = sat_v(ext_v(pot_ff) + ext_v(k_v));
            end else begin
               x_in = sat_v(ext_v(pot_ff) + (ext_v(k_v) >>> 1));
            end
            if (kidx_ff == K_LAST) begin
               state_in = S_DIV_LOAD;
            end else begin
               kidx_in  = kidx_ff + 2'd1;
               state_in = S_K_F;
            end
         end
         S_DIV_LOAD: begin
            div_in   = DB'(u_w[SW:1]);
            quot_in  = '0;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_in  = div_ff << 8;
            quot_in = {quot_ff[DB-9:0], div_step[9:2]};
            rem_in  = div_step[1:0];
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIV_CYC - 1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            x_in     = sat_v(ext_v(pot_ff) + q6_w);
            state_in = S_FIRE;
         end
         S_FIRE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               fired_in     = fire;
               pot_in       = fire ? rest_v : x_ff;
               rsp_valid_in = 1'b1;
               rsp_pot_in   = pot_next_w[DATA_WIDTH-1:0];
               rsp_spike_in = fire;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_FACTOR_RESET;
         step_ff  <= STEP_RATIO_RESET;
         rest_ff  <= REST_POTENTIAL_RESET;
         ext_ff   <= EXTERNAL_DRIVE_RESET;
         sgain_ff <= SYNAPTIC_GAIN_RESET;
         again_ff <= ADAPTATION_GAIN_RESET;
         thr_ff   <= SPIKE_THRESHOLD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_DECAY_FACTOR:    decay_ff <= csr_wdata[RATIO_WIDTH-1:0];
            REG_STEP_RATIO:      step_ff  <= csr_wdata[RATIO_WIDTH-1:0];
            REG_REST_POTENTIAL:  rest_ff  <= csr_wdata;
            REG_EXTERNAL_DRIVE:  ext_ff   <= csr_wdata;
            REG_SYNAPTIC_GAIN:   sgain_ff <= csr_wdata;
            REG_ADAPTATION_GAIN: again_ff <= csr_wdata;
            REG_SPIKE_THRESHOLD: thr_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         syn_ff       <= '0;
         adapt_ff     <= '0;
         pot_ff       <= sat_v(ext_32(REST_POTENTIAL_RESET));
         fired_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_spike_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         syn_ff       <= syn_in;
         adapt_ff     <= adapt_in;
         pot_ff       <= pot_in;
         fired_ff     <= fired_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_spike_ff <= rsp_spike_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff      <= in_in;
      drive_ff   <= drive_in;
      acc_ff     <= acc_in;
      x_ff       <= x_in;
      sum_ff     <= sum_in;
      kidx_ff    <= kidx_in;
      div_ff     <= div_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      rsp_pot_ff <= rsp_pot_in;
   end

   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIRE)
      else $error("response raised outside the fire state");

   a_spike_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_spike_ff == fired_ff)
      else $error("pending spike flag differs from the stored fired flag");

   a_four_slopes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_LOAD |-> $past(kidx_ff) == K_LAST)
      else $error("divide started before all four slopes were summed");

endmodule
